// File: rtl/gsds_pkg.sv
// Shared types and constants of the group scaled int8 dot score block.
`timescale 1ns / 1ps

package gsds_pkg;

    localparam int FIELD_LANES = 8;
    localparam int BYTE_W      = 8;
    localparam int PROD_W      = 16;
    localparam int ACC_W       = 32;
    localparam int SCALE_W     = 32;
    localparam int SCORE_W     = 64;
    localparam int FRAC_W      = 24;
    localparam int CFG_W       = 7;
    localparam int IDX_W       = 2;

    localparam logic [IDX_W-1:0] REG_NUM_COLUMNS  = 2'd0;
    localparam logic [IDX_W-1:0] REG_GRP_SIZE     = 2'd1;
    localparam logic [IDX_W-1:0] REG_GROUPED_MODE = 2'd2;
    localparam logic [IDX_W-1:0] REG_FLOAT_ROWS   = 2'd3;

    localparam logic [CFG_W-1:0] NUM_COLUMNS_RST = 7'd64;
    localparam logic [CFG_W-1:0] GRP_SIZE_RST    = 7'd32;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic row_end;
        logic close;
        logic float_row;
    } ctl_t;

endpackage

// File: rtl/gsds_lane.sv
// One lane: int8 by int8 product of a column pair, masked past the column limit.
`timescale 1ns / 1ps

module gsds_lane
    import gsds_pkg::*;
(
    input  logic                     aclk,
    input  logic                     adv,
    input  logic                     active,
    input  logic [BYTE_W-1:0]        w_byte,
    input  logic [BYTE_W-1:0]        q_byte,
    output logic [PROD_W-1:0]        prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    always_comb begin
        prod_next = active ? (PROD_W'(signed'(w_byte)) * PROD_W'(signed'(q_byte)))
                           : '0;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// File: rtl/gsds_merge.sv
// Lane merge: sums the lane products into the group accumulator and forms the scale product.
`timescale 1ns / 1ps

module gsds_merge
    import gsds_pkg::*;
#(
    parameter int LANES = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      adv,
    input  logic                      in_valid,
    input  ctl_t                      in_ctl,
    input  logic [LANES*PROD_W-1:0]   prod_bus,
    input  logic [SCALE_W-1:0]        gscale,
    input  logic [SCALE_W-1:0]        ascale,
    output logic                      out_valid,
    output ctl_t                      out_ctl,
    output logic                      out_neg,
    output logic [ACC_W-1:0]          out_mag,
    output logic [2*SCALE_W-1:0]      out_scale
);

    logic [ACC_W-1:0]      acc_reg;
    logic [ACC_W-1:0]      acc_next;
    logic [ACC_W-1:0]      lane_sum;
    logic [ACC_W-1:0]      acc_total;
    logic                  valid_reg;
    ctl_t                  ctl_reg;
    logic                  neg_reg;
    logic [ACC_W-1:0]      mag_reg;
    logic [2*SCALE_W-1:0]  scale_reg;

    always_comb begin
        lane_sum = '0;
        for (int i = 0; i < LANES; i++) begin
            lane_sum = lane_sum + {{(ACC_W-PROD_W){prod_bus[i*PROD_W+PROD_W-1]}},
                                   prod_bus[i*PROD_W +: PROD_W]};
        end
        acc_total = acc_reg + lane_sum;
        acc_next  = acc_reg;
        if (adv && in_valid) begin
            acc_next = in_ctl.close ? '0 : acc_total;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            acc_reg <= acc_next;
            if (adv) begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl_reg   <= in_ctl;
            neg_reg   <= acc_total[ACC_W-1];
            mag_reg   <= acc_total[ACC_W-1] ? (~acc_total + ACC_W'(1)) : acc_total;
            scale_reg <= (2*SCALE_W)'(gscale) * (2*SCALE_W)'(ascale);
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_neg   = neg_reg;
    assign out_mag   = mag_reg;
    assign out_scale = scale_reg;

endmodule

// File: rtl/gsds_score.sv
// Score stage: scales the closed group, adds it into the row score with saturation, holds the result.
`timescale 1ns / 1ps

module gsds_score
    import gsds_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      adv,
    input  logic                      in_valid,
    input  ctl_t                      in_ctl,
    input  logic                      in_neg,
    input  logic [ACC_W-1:0]          in_mag,
    input  logic [2*SCALE_W-1:0]      in_scale,
    output logic                      out_valid,
    output logic [SCORE_W-1:0]        out_score,
    output logic                      out_sat
);

    logic [SCALE_W-1:0]         comb_scale;
    logic [SCORE_W-1:0]         mag_prod;
    logic                       st_valid_reg;
    ctl_t                       st_ctl_reg;
    logic                       st_neg_reg;
    logic [SCORE_W-1:0]         st_prod_reg;
    logic signed [SCORE_W-1:0]  row_reg;
    logic signed [SCORE_W-1:0]  row_next;
    logic                       clip_reg;
    logic                       clip_next;
    logic signed [SCORE_W-1:0]  term;
    logic signed [SCORE_W-1:0]  sum;
    logic                       ovf;
    logic signed [SCORE_W-1:0]  row_new;
    logic                       clip_new;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [SCORE_W-1:0]         out_score_reg;
    logic                       out_sat_reg;

    always_comb begin
        comb_scale = (in_scale[2*SCALE_W-1:SCALE_W+FRAC_W] != '0) ? '1
                                                                 : in_scale[SCALE_W+FRAC_W-1:FRAC_W];
        mag_prod   = SCORE_W'(in_mag) * SCORE_W'(comb_scale);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_ctl_reg  <= in_ctl;
            st_neg_reg  <= in_neg;
            st_prod_reg <= mag_prod;
        end
    end

    always_comb begin
        term     = st_neg_reg ? signed'(~st_prod_reg + SCORE_W'(1)) : signed'(st_prod_reg);
        sum      = row_reg + term;
        ovf      = (row_reg[SCORE_W-1] == term[SCORE_W-1]) && (sum[SCORE_W-1] != row_reg[SCORE_W-1]);
        row_new  = ovf ? (term[SCORE_W-1] ? SCORE_MIN : SCORE_MAX) : sum;
        clip_new = clip_reg | ovf;

        row_next       = row_reg;
        clip_next      = clip_reg;
        out_valid_next = out_valid_reg;
        if (adv) begin
            out_valid_next = st_valid_reg && st_ctl_reg.row_end;
            if (st_valid_reg && st_ctl_reg.close) begin
                if (st_ctl_reg.row_end) begin
                    row_next  = '0;
                    clip_next = 1'b0;
                end else begin
                    row_next  = row_new;
                    clip_next = clip_new;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg  <= 1'b0;
            row_reg       <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                st_valid_reg <= in_valid;
            end
            row_reg       <= row_next;
            clip_reg      <= clip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && st_valid_reg && st_ctl_reg.row_end) begin
            out_score_reg <= st_ctl_reg.float_row ? '0 : row_new;
            out_sat_reg   <= st_ctl_reg.float_row ? 1'b0 : clip_new;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_score = out_score_reg;
    assign out_sat   = out_sat_reg;

endmodule

// File: rtl/group_scaled_int8_dot_score.sv
// Top level of the group scaled int8 dot score block.
//
// Scores one int8 embedding row against an int8 query. Each beat on the s_ channel
// carries LANES column pairs plus the group scale and activation scale; s_tlast marks
// the final beat of a row. At each group end the group sum times both scales (Q8.24)
// is added to the row score. One beat leaves on the m_ channel per row: the
// saturating Q.24 score in m_tdata and the clip flag in m_tuser, both zero for float rows.
// Configuration is written through cfg_we / cfg_index / cfg_wdata; the user must do so
// only while idle, as the block does not enforce it. Throughput: one beat per cycle
// while m_tready does not stall, set by the four-stage pipeline (lane products, lane
// merge with scale product, group scaling product, score add).
// Reset (aresetn low, synchronous) clears the row state, the pipeline and the
// registers to their defaults (64 columns, group size 32, grouped mode, int rows).
// A stall on m_tready freezes the whole pipeline; s_tready drops with it, so a
// finished result waits in the output register while nothing is lost.
`timescale 1ns / 1ps

module group_scaled_int8_dot_score
    import gsds_pkg::*;
#(
    parameter int LANES       = 8,
    parameter int MAX_COLUMNS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [191:0]      s_tdata,   // weight_lanes, query_lanes, group_scale, activation_scale
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,   // score
    output logic [0:0]        m_tuser    // saturated
);

    localparam int CW = $clog2(MAX_COLUMNS + LANES + 128);
    localparam int RW = CFG_W + 1;

    logic [CFG_W-1:0]  num_columns_reg;
    logic [CFG_W-1:0]  grp_size_reg;
    logic              grouped_mode_reg;
    logic              float_rows_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     limit;
    logic [CW-1:0]     after;
    logic [CFG_W-1:0]  grp_rem_reg;
    logic [CFG_W-1:0]  grp_rem_next;
    logic [RW-1:0]     grp_sum;
    logic              grp_wrap;
    logic              row_end;
    logic              group_end;
    logic              adv;
    logic              accept;
    ctl_t              in_ctl;

    logic              st1_valid_reg;
    ctl_t              st1_ctl_reg;
    logic [SCALE_W-1:0] st1_gscale_reg;
    logic [SCALE_W-1:0] st1_ascale_reg;

    logic [LANES*PROD_W-1:0] prod_bus;

    logic              mg_valid;
    ctl_t              mg_ctl;
    logic              mg_neg;
    logic [ACC_W-1:0]  mg_mag;
    logic [2*SCALE_W-1:0] mg_scale;

    logic              res_valid;
    logic [SCORE_W-1:0] res_score;
    logic              res_sat;

    assign adv      = !res_valid || m_tready;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_columns_reg  <= NUM_COLUMNS_RST;
            grp_size_reg     <= GRP_SIZE_RST;
            grouped_mode_reg <= 1'b1;
            float_rows_reg   <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_NUM_COLUMNS:  num_columns_reg  <= cfg_wdata;
                REG_GRP_SIZE:     grp_size_reg     <= cfg_wdata;
                REG_GROUPED_MODE: grouped_mode_reg <= cfg_wdata[0];
                REG_FLOAT_ROWS:   float_rows_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        limit     = (CW'(num_columns_reg) < CW'(MAX_COLUMNS)) ? CW'(num_columns_reg)
                                                              : CW'(MAX_COLUMNS);
        after     = count_reg + CW'(LANES);
        row_end   = (after >= limit) || s_tlast;
        grp_sum   = {1'b0, grp_rem_reg} + RW'(LANES);
        grp_wrap  = grp_sum >= {1'b0, grp_size_reg};
        group_end = grouped_mode_reg && (grp_size_reg != '0) && grp_wrap;
        in_ctl.row_end   = row_end;
        in_ctl.close     = row_end || group_end;
        in_ctl.float_row = float_rows_reg;
        count_next   = count_reg;
        grp_rem_next = grp_rem_reg;
        if (accept) begin
            count_next = row_end ? '0 : after;
            if (row_end) begin
                grp_rem_next = '0;
            end else if (grp_wrap) begin
                grp_rem_next = CFG_W'(grp_sum - {1'b0, grp_size_reg});
            end else begin
                grp_rem_next = grp_sum[CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            grp_rem_reg   <= '0;
            st1_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            grp_rem_reg <= grp_rem_next;
            if (adv) begin
                st1_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st1_ctl_reg    <= in_ctl;
            st1_gscale_reg <= s_tdata[128 +: SCALE_W];
            st1_ascale_reg <= s_tdata[160 +: SCALE_W];
        end
    end

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        logic [BYTE_W-1:0] w_byte;
        logic [BYTE_W-1:0] q_byte;
        logic              active;

        if (i < FIELD_LANES) begin : g_field
            assign w_byte = s_tdata[i*BYTE_W +: BYTE_W];
            assign q_byte = s_tdata[64 + i*BYTE_W +: BYTE_W];
        end else begin : g_pad
            assign w_byte = '0;
            assign q_byte = '0;
        end

        assign active = (count_reg + CW'(i)) < limit;

        gsds_lane u_lane (
            .aclk   (aclk),
            .adv    (adv),
            .active (active),
            .w_byte (w_byte),
            .q_byte (q_byte),
            .prod   (prod_bus[i*PROD_W +: PROD_W])
        );
    end

    gsds_merge #(
        .LANES (LANES)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (st1_valid_reg),
        .in_ctl    (st1_ctl_reg),
        .prod_bus  (prod_bus),
        .gscale    (st1_gscale_reg),
        .ascale    (st1_ascale_reg),
        .out_valid (mg_valid),
        .out_ctl   (mg_ctl),
        .out_neg   (mg_neg),
        .out_mag   (mg_mag),
        .out_scale (mg_scale)
    );

    gsds_score u_score (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (mg_valid),
        .in_ctl    (mg_ctl),
        .in_neg    (mg_neg),
        .in_mag    (mg_mag),
        .in_scale  (mg_scale),
        .out_valid (res_valid),
        .out_score (res_score),
        .out_sat   (res_sat)
    );

    assign m_tvalid   = res_valid;
    assign m_tdata    = res_score;
    assign m_tuser[0] = res_sat;

endmodule

// File: rtl/gsds_check.sv
// Port-level checks of the group scaled int8 dot score block and their binding.
`timescale 1ns / 1ps

module gsds_check (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata,
    input logic [0:0]   m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_ready_follows_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not track the output slot");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while the result is stalled");

endmodule

bind group_scaled_int8_dot_score gsds_check u_gsds_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
